[hw/rtl/spring_offset_velocity_update_top_assert.svh]
// Assertion macros for the spring offset velocity update block.
`ifndef SPRING_OFFSET_VELOCITY_UPDATE_TOP_ASSERT_SVH
`define SPRING_OFFSET_VELOCITY_UPDATE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked on clk_i, disabled while reset is low.
`define SOVU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i, also while reset is low.
`define SOVU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SOVU_ASSERT(lbl, prop, msg)
`define SOVU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/sovu_pkg.sv]
// Package with constants and types of the spring offset velocity update block.
`default_nettype none
package sovu_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ANCHOR_X   = 3'd0;
  localparam logic [2:0] CFG_ANCHOR_Y   = 3'd1;
  localparam logic [2:0] CFG_ANCHOR_Z   = 3'd2;
  localparam logic [2:0] CFG_REST_DIST  = 3'd3;
  localparam logic [2:0] CFG_TIME_SCALE = 3'd4;
  localparam logic [2:0] CFG_TARGET_EN  = 3'd5;

  // 600.0 in Q16.16: at or above this time scale the spring is off.
  localparam logic [30:0] MAX_SCALE_Q = 31'd39321600;
  localparam logic [30:0] TS_RESET    = 31'h7FFF_FFFF;

  // Pipeline geometry.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 48;
  localparam int U_BITS     = 31;
  localparam int B_BITS     = 17;
  localparam int LAT        = 3 + SQRT_STEPS + 1 + DIV_STEPS + 9;

  localparam int IN_W  = 224;
  localparam int OUT_W = 96;

  // Data carried alongside the distance computation.
  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0][32:0] am;
    logic [2:0]       neg;
    logic             big;
    logic             pass;
    logic [30:0]      dt;
  } front_t;

  // Data carried alongside the divider section.
  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0]       neg;
    logic             pass;
    logic             rneg;
    logic             sat_r;
    logic             sat_b;
    logic [32:0]      len;
  } mid_t;

  // Data carried through the back end.
  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0]       neg;
    logic             pass;
    logic [2:0][30:0] um;
  } back_t;

  typedef struct packed {
    logic [2:0][31:0] nv;
    logic             applied;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/spring_offset_velocity_update_top.sv]
// Top level of the spring offset velocity update pipeline.
`default_nettype none
`include "spring_offset_velocity_update_top_assert.svh"
// Spring offset velocity update: takes one body (position, velocity, time step, Q16.16) per
// cycle while not frozen and returns its new velocity with an applied flag, saturated to
// Q16.16. The block is a fixed pipeline of 93 stages followed by an output register, most of
// them the 32-stage square root and the 48-stage restoring dividers, and one request
// enters every cycle while it runs. A two-entry output buffer keeps accepting while a finished
// result waits; the pipeline freezes only when both entries are full. Configuration is to be
// written by the user only while idle; nothing in the block enforces this.
module spring_offset_velocity_update_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [2:0]                cfg_idx_i,
  input  wire logic [31:0]               cfg_data_i,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, step_time, zero pad
  input  wire logic [sovu_pkg::IN_W-1:0] s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // new_vel_x, new_vel_y, new_vel_z
  output logic [sovu_pkg::OUT_W-1:0]     m_axis_tdata_o,
  // applied
  output logic                           m_axis_tuser_o
);
  import sovu_pkg::*;

  // Configuration registers.
  logic [31:0] anc_x_q, anc_y_q, anc_z_q;
  logic [30:0] rest_q, ts_q;
  logic        ten_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anc_x_q <= '0;
      anc_y_q <= '0;
      anc_z_q <= '0;
      rest_q  <= '0;
      ts_q    <= TS_RESET;
      ten_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ANCHOR_X:   anc_x_q <= cfg_data_i;
        CFG_ANCHOR_Y:   anc_y_q <= cfg_data_i;
        CFG_ANCHOR_Z:   anc_z_q <= cfg_data_i;
        CFG_REST_DIST:  rest_q  <= cfg_data_i[30:0];
        CFG_TIME_SCALE: ts_q    <= cfg_data_i[30:0];
        CFG_TARGET_EN:  ten_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A zero time scale divides as one LSB.
  logic [30:0] tse;
  assign tse = (ts_q == '0) ? 31'd1 : ts_q;

  // Global pipeline advance: frozen only while the skid entry is occupied.
  logic en, skid_v_q;
  assign en = !skid_v_q;
  assign s_axis_tready_o = en;

  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  // Stage A: axis from the anchor, magnitudes and pass-through decision.
  logic [2:0][31:0] pos_in, anc;
  front_t a_d, a_q;
  assign anc = {anc_z_q, anc_y_q, anc_x_q};
  always_comb begin
    logic [32:0] dd;
    a_d = '0;
    for (int i = 0; i < 3; i++) begin
      pos_in[i]  = s_axis_tdata_i[32*i +: 32];
      a_d.vel[i] = s_axis_tdata_i[96 + 32*i +: 32];
      dd = {pos_in[i][31], pos_in[i]} - {anc[i][31], anc[i]};
      a_d.neg[i] = dd[32];
      a_d.am[i]  = dd[32] ? (33'd0 - dd) : dd;
    end
    a_d.big  = a_d.am[0][32] | a_d.am[0][31] | a_d.am[1][32] | a_d.am[1][31]
             | a_d.am[2][32] | a_d.am[2][31];
    a_d.dt   = s_axis_tdata_i[222:192];
    a_d.pass = !ten_q || (ts_q >= MAX_SCALE_Q);
  end
  always_ff @(posedge clk_i) begin
    if (en) a_q <= a_d;
  end

  // Stage B: squares of the (halved when large) axis components.
  front_t b_q;
  logic [2:0][63:0] sq_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q <= a_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= a_q.big ? (64'(a_q.am[i][32:1]) * 64'(a_q.am[i][32:1]))
                           : (64'(a_q.am[i][31:0]) * 64'(a_q.am[i][31:0]));
      end
    end
  end

  // Stage C (root index 0): sum of squares.
  logic [63:0] sx_q [SQRT_STEPS+1];
  logic [63:0] sr_q [SQRT_STEPS+1];
  front_t      sc_q [SQRT_STEPS+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q[0] <= sq_q[0] + sq_q[1] + sq_q[2];
      sr_q[0] <= '0;
      sc_q[0] <= b_q;
    end
  end

  // Square root: one result bit per stage.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] trial;
    assign trial = sr_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sc_q[k+1] <= sc_q[k];
        if (sx_q[k] >= trial) begin
          sx_q[k+1] <= sx_q[k] - trial;
          sr_q[k+1] <= (sr_q[k] >> 1) + BIT;
        end else begin
          sx_q[k+1] <= sx_q[k];
          sr_q[k+1] <= sr_q[k] >> 1;
        end
      end
    end
  end

  // Stage D (divider index 0): distance, spring offset and divider setup.
  mid_t             dc_q [DIV_STEPS+1];
  logic [2:0][62:0] urem_q [DIV_STEPS+1];
  logic [2:0][30:0] uq_q   [DIV_STEPS+1];
  logic [48:0]      rrem_q [DIV_STEPS+1];
  logic [47:0]      rq_q   [DIV_STEPS+1];
  logic [46:0]      brem_q [DIV_STEPS+1];
  logic [16:0]      bq_q   [DIV_STEPS+1];

  front_t      sf;
  logic [32:0] axis_len;
  logic [34:0] rd;
  logic [32:0] mr;
  assign sf       = sc_q[SQRT_STEPS];
  assign axis_len = sf.big ? {sr_q[SQRT_STEPS][31:0], 1'b0} : {1'b0, sr_q[SQRT_STEPS][31:0]};
  assign rd       = {2'b0, axis_len} - {4'b0, rest_q};
  assign mr       = rd[34] ? 33'(35'd0 - rd) : rd[32:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dc_q[0].vel   <= sf.vel;
      dc_q[0].neg   <= sf.neg;
      dc_q[0].pass  <= sf.pass || (axis_len == '0);
      dc_q[0].rneg  <= rd[34];
      dc_q[0].sat_r <= {30'b0, mr} >= {tse, 32'b0};
      dc_q[0].sat_b <= {1'b0, sf.dt} >= {tse, 1'b0};
      dc_q[0].len   <= axis_len;
      for (int i = 0; i < 3; i++) urem_q[0][i] <= {sf.am[i], 30'b0};
      uq_q[0]   <= '0;
      rrem_q[0] <= {mr, 16'b0};
      rq_q[0]   <= '0;
      brem_q[0] <= {sf.dt, 16'b0};
      bq_q[0]   <= '0;
    end
  end

  // Restoring dividers: one quotient bit per stage in each lane until its quotient is complete.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int KR = DIV_STEPS - 1 - j;
    always_ff @(posedge clk_i) begin
      if (en) begin
        dc_q[j+1] <= dc_q[j];
        if ((rrem_q[j] >> KR) >= 49'(tse)) begin
          rrem_q[j+1]   <= rrem_q[j] - (49'(tse) << KR);
          rq_q[j+1]     <= rq_q[j] | (48'd1 << KR);
        end else begin
          rrem_q[j+1]   <= rrem_q[j];
          rq_q[j+1]     <= rq_q[j];
        end
      end
    end

    if (j < U_BITS) begin : g_u
      localparam int KU = U_BITS - 1 - j;
      always_ff @(posedge clk_i) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            if ((urem_q[j][i] >> KU) >= 63'(dc_q[j].len)) begin
              urem_q[j+1][i] <= urem_q[j][i] - (63'(dc_q[j].len) << KU);
              uq_q[j+1][i]   <= uq_q[j][i] | (31'd1 << KU);
            end else begin
              urem_q[j+1][i] <= urem_q[j][i];
              uq_q[j+1][i]   <= uq_q[j][i];
            end
          end
        end
      end
    end else begin : g_u_hold
      always_ff @(posedge clk_i) begin
        if (en) begin
          urem_q[j+1] <= urem_q[j];
          uq_q[j+1]   <= uq_q[j];
        end
      end
    end

    if (j < B_BITS) begin : g_b
      localparam int KB = B_BITS - 1 - j;
      always_ff @(posedge clk_i) begin
        if (en) begin
          if ((brem_q[j] >> KB) >= 47'(tse)) begin
            brem_q[j+1] <= brem_q[j] - (47'(tse) << KB);
            bq_q[j+1]   <= bq_q[j] | (17'd1 << KB);
          end else begin
            brem_q[j+1] <= brem_q[j];
            bq_q[j+1]   <= bq_q[j];
          end
        end
      end
    end else begin : g_b_hold
      always_ff @(posedge clk_i) begin
        if (en) begin
          brem_q[j+1] <= brem_q[j];
          bq_q[j+1]   <= bq_q[j];
        end
      end
    end
  end

  // Stage E: clamp the unit axis, sign the spring rate, clamp the blend.
  mid_t             df;
  back_t            e_q;
  logic [2:0][31:0] eu_q;
  logic [49:0]      er_q;
  logic [16:0]      eb_q;
  assign df = dc_q[DIV_STEPS];
  always_ff @(posedge clk_i) begin
    logic [30:0] um;
    logic [48:0] rq;
    if (en) begin
      e_q.vel  <= df.vel;
      e_q.neg  <= df.neg;
      e_q.pass <= df.pass;
      for (int i = 0; i < 3; i++) begin
        um = (uq_q[DIV_STEPS][i] > 31'h4000_0000) ? 31'h4000_0000 : uq_q[DIV_STEPS][i];
        e_q.um[i] <= um;
        eu_q[i]   <= df.neg[i] ? (32'd0 - {1'b0, um}) : {1'b0, um};
      end
      rq   = df.sat_r ? 49'h1_0000_0000_0000 : {1'b0, rq_q[DIV_STEPS]};
      er_q <= df.rneg ? (50'd0 - {1'b0, rq}) : {1'b0, rq};
      eb_q <= (df.sat_b || bq_q[DIV_STEPS] > 17'h1_0000) ? 17'h1_0000 : bq_q[DIV_STEPS];
    end
  end

  // Stage F: velocity times unit axis, per component.
  back_t            f_q;
  logic [2:0][63:0] fp_q;
  logic [49:0]      fr_q;
  logic [16:0]      fb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q  <= e_q;
      fr_q <= er_q;
      fb_q <= eb_q;
      for (int i = 0; i < 3; i++) begin
        fp_q[i] <= $signed(e_q.vel[i]) * $signed(eu_q[i]);
      end
    end
  end

  // Stage G: dot product sum.
  back_t       g_q;
  logic [65:0] gs_q;
  logic [49:0] gr_q;
  logic [16:0] gb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q  <= f_q;
      gr_q <= fr_q;
      gb_q <= fb_q;
      gs_q <= {{2{fp_q[0][63]}}, fp_q[0]} + {{2{fp_q[1][63]}}, fp_q[1]}
            + {{2{fp_q[2][63]}}, fp_q[2]};
    end
  end

  // Stage H: parallel speed back to Q16.16, truncated toward zero.
  back_t       h_q;
  logic [36:0] hp_q;
  logic [49:0] hr_q;
  logic [16:0] hb_q;
  always_ff @(posedge clk_i) begin
    logic [65:0] mg;
    logic [35:0] sh;
    if (en) begin
      h_q  <= g_q;
      hr_q <= gr_q;
      hb_q <= gb_q;
      mg   = gs_q[65] ? (66'd0 - gs_q) : gs_q;
      sh   = mg[65:30];
      hp_q <= gs_q[65] ? (37'd0 - {1'b0, sh}) : {1'b0, sh};
    end
  end

  // Stage I: spring rate plus parallel speed, clamped.
  back_t       i_q;
  logic [46:0] ism_q;
  logic        isn_q;
  logic [16:0] ib_q;
  always_ff @(posedge clk_i) begin
    logic [50:0] s;
    logic [50:0] sm;
    if (en) begin
      i_q  <= h_q;
      ib_q <= hb_q;
      s    = {hr_q[49], hr_q} + {{14{hp_q[36]}}, hp_q};
      sm   = s[50] ? (51'd0 - s) : s;
      isn_q <= s[50];
      ism_q <= (sm > 51'h7FFF_FFFF_FFFF) ? 47'h7FFF_FFFF_FFFF : sm[46:0];
    end
  end

  // Stage J: blend times scalar, as two partial products.
  back_t       j_q;
  logic [40:0] jl_q;
  logic [39:0] jh_q;
  logic        jsn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      j_q   <= i_q;
      jsn_q <= isn_q;
      jl_q  <= 41'(ib_q) * 41'(ism_q[23:0]);
      jh_q  <= 40'(ib_q) * 40'(ism_q[46:24]);
    end
  end

  // Stage K: correction magnitude, shifted and clamped.
  back_t       k_q;
  logic [32:0] kc_q;
  logic        ksn_q;
  always_ff @(posedge clk_i) begin
    logic [63:0] tot;
    if (en) begin
      k_q   <= j_q;
      ksn_q <= jsn_q;
      tot   = {jh_q, 24'b0} + {23'b0, jl_q};
      kc_q  <= (tot[63:16] > 48'h1_0000_0000) ? 33'h1_0000_0000 : tot[48:16];
    end
  end

  // Stage L: correction times unit axis, per component.
  back_t            l_q;
  logic [2:0][63:0] lp_q;
  logic [2:0]       lsn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      l_q <= k_q;
      for (int i = 0; i < 3; i++) begin
        lp_q[i]  <= 64'(kc_q) * 64'(k_q.um[i]);
        lsn_q[i] <= ksn_q ^ k_q.neg[i];
      end
    end
  end

  // Stage M: subtract and saturate, or pass the velocity through.
  res_t m_q;
  always_ff @(posedge clk_i) begin
    logic [35:0] t;
    logic [35:0] nv;
    if (en) begin
      m_q.applied <= !l_q.pass;
      for (int i = 0; i < 3; i++) begin
        t  = {2'b0, lp_q[i][63:30]};
        nv = {{4{l_q.vel[i][31]}}, l_q.vel[i]} - (lsn_q[i] ? (36'd0 - t) : t);
        if (l_q.pass) begin
          m_q.nv[i] <= l_q.vel[i];
        end else if (!nv[35] && nv[34:31] != 4'b0000) begin
          m_q.nv[i] <= 32'h7FFF_FFFF;
        end else if (nv[35] && nv[34:31] != 4'b1111) begin
          m_q.nv[i] <= 32'h8000_0000;
        end else begin
          m_q.nv[i] <= nv[31:0];
        end
      end
    end
  end

  // Output register with a skid entry behind it.
  res_t out_q, skid_q;
  logic out_v_q;
  logic push, take;
  assign push = en && vld_q[LAT-1];
  assign take = out_v_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) skid_v_q <= 1'b0;
    end else if (push) begin
      if (!out_v_q || take) out_v_q  <= 1'b1;
      else                  skid_v_q <= 1'b1;
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) out_q <= skid_q;
    end else if (push) begin
      if (!out_v_q || take) out_q  <= m_q;
      else                  skid_q <= m_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.nv[2], out_q.nv[1], out_q.nv[0]};
  assign m_axis_tuser_o  = out_q.applied;

  // Checks on the output buffer.
  `SOVU_ASSERT_ALWAYS(a_skid_has_out, skid_v_q |-> out_v_q, "skid entry full without output")
  `SOVU_ASSERT(a_skid_holds, skid_v_q && !m_axis_tready_i |=> skid_v_q, "skid entry lost")
  `SOVU_ASSERT(a_skid_fill, $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready_i),
               "skid filled while output free")

endmodule
`default_nettype wire

[verif/spring_offset_velocity_update_top_tb.sv]
// Testbench for the spring offset velocity update pipeline: directed and random streams against a predictor.
`timescale 1ns / 1ps
module spring_offset_velocity_update_top_tb;
  import sovu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic [2:0][31:0] nv;
    logic             applied;
  } vel_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  spring_offset_velocity_update_top dut (.*);

  // Shadow copy of the configuration registers.
  longint anc_q[3];
  longint unsigned rest_q, tscale_q, ten_q;

  logic [IN_W-1:0] body_queue[$];
  vel_res_t        vel_expected[$];
  int unsigned     req_accepted, req_sent, res_seen, applied_seen, errors;
  int              in_gap, out_stall, watchdog;
  bit              no_idle;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat32(longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic longint shr_tz(longint x, int n);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : x;
    m = m >> n;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Expected new velocity of one body under the current register values.
  function automatic vel_res_t predict_velocity(logic [IN_W-1:0] body);
    vel_res_t res;
    longint v[3], d[3], u[3];
    longint unsigned am[3], sum, axis_len, tsv, dt, q, bq, e;
    longint p, r, s, c;
    bit big;
    sum = 0;
    big = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(body[32*(i+3) +: 32]));
      d[i] = longint'($signed(body[32*i +: 32])) - anc_q[i];
      am[i] = (d[i] < 0) ? longint'(-d[i]) : d[i];
      if (am[i] >= 64'h8000_0000) big = 1;
      res.nv[i] = sat32(v[i]);
    end
    res.applied = 1'b0;
    dt = body[222:192];
    tsv = (tscale_q == 0) ? 1 : tscale_q;
    if (ten_q == 0 || tscale_q >= MAX_SCALE_Q) return res;
    for (int i = 0; i < 3; i++) begin
      e = big ? (am[i] >> 1) : am[i];
      sum += e * e;
    end
    axis_len = floor_sqrt(sum);
    if (big) axis_len = axis_len << 1;
    if (axis_len == 0) return res;
    p = 0;
    for (int i = 0; i < 3; i++) begin
      q = (am[i] << 30) / axis_len;
      if (q > 64'd1073741824) q = 64'd1073741824;
      u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
      p += v[i] * u[i];
    end
    p = shr_tz(p, 30);
    r = longint'(axis_len) - longint'(rest_q);
    r = (r < 0) ? -longint'((longint'(-r) << 16) / tsv) : longint'((r << 16) / tsv);
    bq = (dt << 16) / tsv;
    if (bq > 64'd65536) bq = 64'd65536;
    s = clamp(r + p, 64'sd140737488355327);
    c = clamp(shr_tz(longint'(bq) * s, 16), 64'sd4294967296);
    for (int i = 0; i < 3; i++) res.nv[i] = sat32(v[i] - shr_tz(c * u[i], 30));
    res.applied = 1'b1;
    return res;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 65) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Request driver: holds each request until it is accepted.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (s_axis_tvalid_i && req_accepted != req_sent) begin
      s_axis_tvalid_i <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      s_axis_tvalid_i <= 1'b0;
    end else if (body_queue.size() > 0) begin
      s_axis_tdata_i <= body_queue.pop_front();
      s_axis_tvalid_i <= 1'b1;
      req_sent <= req_sent + 1;
      in_gap <= pick_gap();
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // Result side back-pressure.
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  // Monitor: predicts accepted requests and checks results in order.
  always @(posedge clk_i) begin
    vel_res_t exp_res;
    logic fired;
    fired = 1'b0;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      vel_expected.push_back(predict_velocity(s_axis_tdata_i));
      req_accepted <= req_accepted + 1;
      fired = 1'b1;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      fired = 1'b1;
      res_seen <= res_seen + 1;
      if (vel_expected.size() == 0) begin
        $error("result with no request pending");
        errors <= errors + 1;
      end else begin
        exp_res = vel_expected.pop_front();
        if (exp_res.applied) applied_seen <= applied_seen + 1;
        for (int i = 0; i < 3; i++) begin
          if (m_axis_tdata_o[32*i +: 32] !== exp_res.nv[i]) begin
            $error("new_vel_%s expected %h actual %h",
                   (i == 0) ? "x" : ((i == 1) ? "y" : "z"), exp_res.nv[i],
                   m_axis_tdata_o[32*i +: 32]);
            errors <= errors + 1;
          end
        end
        if (m_axis_tuser_o !== exp_res.applied) begin
          $error("applied expected %b actual %b", exp_res.applied, m_axis_tuser_o);
          errors <= errors + 1;
        end
      end
    end
    watchdog <= fired ? 0 : watchdog + 1;
  end

  // Watchdog on stalled traffic.
  always @(posedge clk_i) begin
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_ANCHOR_X:   anc_q[0] = longint'($signed(data));
      CFG_ANCHOR_Y:   anc_q[1] = longint'($signed(data));
      CFG_ANCHOR_Z:   anc_q[2] = longint'($signed(data));
      CFG_REST_DIST:  rest_q = data[30:0];
      CFG_TIME_SCALE: tscale_q = data[30:0];
      CFG_TARGET_EN:  ten_q = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                            logic [31:0] rest, logic [31:0] ts, logic en);
    write_reg(CFG_ANCHOR_X, ax);
    write_reg(CFG_ANCHOR_Y, ay);
    write_reg(CFG_ANCHOR_Z, az);
    write_reg(CFG_REST_DIST, rest);
    write_reg(CFG_TIME_SCALE, ts);
    write_reg(CFG_TARGET_EN, {31'd0, en});
  endtask

  task automatic wait_idle();
    wait (body_queue.size() == 0 && vel_expected.size() == 0 && !s_axis_tvalid_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [IN_W-1:0] make_body(logic [2:0][31:0] pos, logic [2:0][31:0] vel,
                                                logic [30:0] dt);
    return {1'b0, dt, vel, pos};
  endfunction

  // Coordinate near the anchor, small, extreme or fully random.
  function automatic logic [31:0] rand_coord(int axis);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 32'(anc_q[axis] + longint'($urandom_range(0, 32'h0008_0000))
                            - 64'sh0004_0000);
    if (sel < 6) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    if (sel < 7) return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom();
  endfunction

  function automatic logic [31:0] rand_vel();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    if (sel < 6) return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom();
  endfunction

  function automatic logic [30:0] rand_dt();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 31'($urandom_range(0, 32'h0002_0000));
    if (sel < 7) return ($urandom_range(0, 1)) ? 31'h7FFF_FFFF : 31'd0;
    return 31'($urandom());
  endfunction

  task automatic queue_random(int count);
    logic [2:0][31:0] pos, vel;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] = rand_coord(i);
        vel[i] = rand_vel();
      end
      body_queue.push_back(make_body(pos, vel, rand_dt()));
    end
  endtask

  // Stimulus: directed corners, then random phases over several register settings.
  initial begin
    logic [2:0][31:0] pos, vel;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ANCHOR_X;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    req_accepted = 0; req_sent = 0; res_seen = 0; applied_seen = 0; errors = 0;
    in_gap = 0; out_stall = 0; watchdog = 0; no_idle = 0;
    anc_q[0] = 0; anc_q[1] = 0; anc_q[2] = 0;
    rest_q = 0; tscale_q = TS_RESET; ten_q = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset state: spring disabled, everything passes through.
    queue_random(20);
    wait_idle();

    // Directed corners with a moderate time scale.
    set_config(32'h0001_0000, 32'hFFFE_0000, 32'd0, 32'h0001_8000, 32'h0002_0000, 1'b1);
    pos = {32'd0, 32'hFFFE_0000, 32'h0001_0000};
    body_queue.push_back(make_body(pos, {32'd5, 32'd6, 32'd7}, 31'h0000_8000));  // on anchor
    pos = {32'd0, 32'hFFFE_0000, 32'h0001_0001};
    body_queue.push_back(make_body(pos, {32'd0, 32'd0, 32'h0001_0000}, 31'h0001_0000));
    pos = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    vel = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    body_queue.push_back(make_body(pos, vel, 31'h7FFF_FFFF));
    pos = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    vel = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    body_queue.push_back(make_body(pos, vel, 31'd0));
    body_queue.push_back(make_body(pos, {32'h7FFF_FFFF, 32'h8000_0000, 32'd0}, 31'h7FFF_FFFF));
    pos = {32'h0000_1000, 32'h0004_0000, 32'h8000_0000};
    body_queue.push_back(make_body(pos, {32'd0, 32'h0010_0000, 32'hFFF0_0000}, 31'h0002_0000));
    wait_idle();

    // Smallest and zero time scale, huge anchor offsets.
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b1);
    pos = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    body_queue.push_back(make_body(pos, {32'd1, 32'hFFFF_FFFF, 32'd3}, 31'h0000_0001));
    body_queue.push_back(make_body(pos, {32'h7FFF_FFFF, 32'd0, 32'h8000_0000}, 31'd0));
    queue_random(200);
    wait_idle();
    write_reg(CFG_TIME_SCALE, 32'd1);
    queue_random(200);
    wait_idle();

    // Time scale just below and at the 600 second cutoff.
    set_config(32'd0, 32'd0, 32'd0, 32'd0, MAX_SCALE_Q - 1, 1'b1);
    queue_random(200);
    wait_idle();
    write_reg(CFG_TIME_SCALE, MAX_SCALE_Q);
    queue_random(100);
    wait_idle();

    // Typical settings, one phase without idling.
    no_idle = 1;
    set_config($urandom(), $urandom(), $urandom(), 32'h0003_0000, 32'h0000_8000, 1'b1);
    queue_random(300);
    wait_idle();
    no_idle = 0;
    set_config(32'h0010_0000, 32'hFFF0_0000, 32'h0000_4000, $urandom_range(0, 32'h0010_0000),
               $urandom_range(1, 32'h0040_0000), 1'b1);
    queue_random(350);
    wait_idle();
    set_config($urandom(), $urandom(), $urandom(), $urandom() >> 1, 32'h7FFF_FFFF, 1'b0);
    queue_random(100);
    wait_idle();
    set_config(32'd0, 32'd0, 32'd0, 32'h0001_0000, $urandom_range(1, 32'h0100_0000), 1'b1);
    queue_random(280);
    wait_idle();

    $display("Checked %0d velocity results, %0d with the spring applied.", res_seen,
             applied_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sovu_pkg.sv
hw/rtl/spring_offset_velocity_update_top.sv
verif/spring_offset_velocity_update_top_tb.sv
